### rtl/core/miller_rabin_prime_test_macros.svh
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_macros.svh
// assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_MACROS_SVH

// same-cycle implication
`define MRPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// widths, register indexes and shared types of the prime tester
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int WIDTH         = 32;
    localparam int MAX_WITNESSES = 4;
    localparam int NUM_WREGS     = 4;
    localparam int CNT_W         = $clog2(WIDTH);
    localparam int WIT_IDX_W     = (MAX_WITNESSES > 1) ? $clog2(MAX_WITNESSES) : 1;
    localparam int K_W           = $clog2(MAX_WITNESSES + 1);
    localparam int COUNT_W       = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WITNESS_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WITNESS_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WITNESS_LAST  = 3'd4;

    localparam logic [COUNT_W-1:0]    COUNT_RESET = 3'd3;
    localparam logic [CFG_DATA_W-1:0] WIT_RESET [NUM_WREGS] = '{32'd2, 32'd7, 32'd61, 32'd0};

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] addend;
        logic [WIDTH-1:0] multiplier;
    } mm_req_t;

endpackage

### rtl/core/mrpt_modmul.sv
// ----------------------------------------------------------------------------
// mrpt_modmul
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module mrpt_modmul
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mrpt_pkg::mm_req_t         req,
    input  logic [mrpt_pkg::WIDTH-1:0] modulus,
    output logic                      done,
    output logic [mrpt_pkg::WIDTH-1:0] product
);
    import mrpt_pkg::*;

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] n1;
    logic [WIDTH+1:0] n2;

    // acc = 2*acc + bit*a, then at most two subtractions of n
    always_comb
    begin
        n1  = {2'b00, modulus};
        n2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + (b_reg[WIDTH-1] ? {2'b00, a_reg} : '0);
        if (sum >= n2)
        begin
            acc_next = WIDTH'(sum - n2);
        end
        else if (sum >= n1)
        begin
            acc_next = WIDTH'(sum - n1);
        end
        else
        begin
            acc_next = sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= req.addend;
            b_reg   <= req.multiplier;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### rtl/core/miller_rabin_prime_test.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test
// Miller-Rabin probable-prime test over up to four configured witnesses
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one candidate per transaction;
//   output channel out_valid/out_ready returns one is_probable_prime bit.
//   one candidate is worked on at a time; in_ready is high only when idle.
//   every modular product goes through one shared bit-serial multiplier,
//   so that unit sets the latency. a candidate below 2 goes straight to
//   the finish state; each witness is reduced mod the candidate (skipped
//   if 0), then raised to the power d, squarings skipped while the power
//   is 1, then squared while the value is neither 1 nor n-1.
//   a finished result waits in the output register; a new candidate is
//   taken meanwhile, and its own result waits until the old one is taken.
//   configuration writes (cfg_we, cfg_index, cfg_data) land at once and
//   must come only while idle. reset restores witness_count 3 and the
//   witnesses 2, 7, 61, 0, empties the output and returns to idle.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mrpt_pkg::WIDTH-1:0]       candidate,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             is_probable_prime,
    input  logic                             cfg_we,
    input  logic [mrpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrpt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mrpt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPLIT = 4'd1;
    localparam logic [3:0] S_WNEXT = 4'd2;
    localparam logic [3:0] S_RED   = 4'd3;
    localparam logic [3:0] S_PSQ   = 4'd4;
    localparam logic [3:0] S_PSQW  = 4'd5;
    localparam logic [3:0] S_PMUL  = 4'd6;
    localparam logic [3:0] S_PMULW = 4'd7;
    localparam logic [3:0] S_PNXT  = 4'd8;
    localparam logic [3:0] S_CHK   = 4'd9;
    localparam logic [3:0] S_SQL   = 4'd10;
    localparam logic [3:0] S_SQW   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [WIDTH-1:0]   n_reg, n_next;
    logic [WIDTH-1:0]   nm1_reg, nm1_next;
    logic [WIDTH-1:0]   d_reg, d_next;
    logic [WIDTH-1:0]   dsh_reg, dsh_next;
    logic [WIDTH-1:0]   base_reg, base_next;
    logic [WIDTH-1:0]   x_reg, x_next;
    logic [CNT_W-1:0]   s_reg, s_next;
    logic [CNT_W-1:0]   e_reg, e_next;
    logic [CNT_W-1:0]   r_reg, r_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic               res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic               prime_reg, prime_next;

    logic [COUNT_W-1:0] count_reg;
    logic [WIDTH-1:0]   wit_reg [MAX_WITNESSES];
    logic [K_W-1:0]     cnt_eff;

    mm_req_t            mm_req;
    logic               mm_done;
    logic [WIDTH-1:0]   mm_product;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            for (int i = 0; i < MAX_WITNESSES; i++)
            begin
                wit_reg[i] <= (i < NUM_WREGS) ? WIDTH'(WIT_RESET[i]) : '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WITNESS_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_WITNESSES; i++)
            begin
                if (i < NUM_WREGS &&
                    cfg_index == REG_WITNESS_0 + CFG_IDX_W'(i) &&
                    cfg_index <= REG_WITNESS_LAST)
                begin
                    wit_reg[i] <= WIDTH'(cfg_data);
                end
            end
        end
    end

    assign cnt_eff = (32'(count_reg) > MAX_WITNESSES) ? K_W'(MAX_WITNESSES)
                                                      : K_W'(count_reg);

    mrpt_modmul u_modmul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .modulus (n_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        nm1_next       = nm1_reg;
        d_next         = d_reg;
        dsh_next       = dsh_reg;
        base_next      = base_reg;
        x_next         = x_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mm_req.start      = 1'b0;
        mm_req.addend     = x_reg;
        mm_req.multiplier = x_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next   = candidate;
                    nm1_next = candidate - 1'b1;
                    d_next   = candidate - 1'b1;
                    s_next   = '0;
                    k_next   = '0;
                    if (candidate < WIDTH'(2))
                    begin
                        res_next   = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SPLIT;
                    end
                end
            end
            S_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[WIDTH-1:1]};
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    state_next = S_WNEXT;
                end
            end
            S_WNEXT:
            begin
                if (k_reg >= cnt_eff)
                begin
                    res_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    // witness mod n as 1 * witness mod n
                    mm_req.start      = 1'b1;
                    mm_req.addend     = WIDTH'(1);
                    mm_req.multiplier = wit_reg[k_reg[WIT_IDX_W-1:0]];
                    state_next        = S_RED;
                end
            end
            S_RED:
            begin
                if (mm_done)
                begin
                    base_next = mm_product;
                    if (mm_product == '0)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_WNEXT;
                    end
                    else
                    begin
                        x_next     = WIDTH'(1);
                        dsh_next   = d_reg;
                        e_next     = CNT_W'(WIDTH - 1);
                        state_next = S_PSQ;
                    end
                end
            end
            S_PSQ:
            begin
                if (x_reg == WIDTH'(1))
                begin
                    state_next = S_PMUL;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    state_next   = S_PSQW;
                end
            end
            S_PSQW:
            begin
                if (mm_done)
                begin
                    x_next     = mm_product;
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                if (dsh_reg[WIDTH-1])
                begin
                    mm_req.start      = 1'b1;
                    mm_req.multiplier = base_reg;
                    state_next        = S_PMULW;
                end
                else
                begin
                    state_next = S_PNXT;
                end
            end
            S_PMULW:
            begin
                if (mm_done)
                begin
                    x_next     = mm_product;
                    state_next = S_PNXT;
                end
            end
            S_PNXT:
            begin
                dsh_next = {dsh_reg[WIDTH-2:0], 1'b0};
                if (e_reg == '0)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    e_next     = e_reg - 1'b1;
                    state_next = S_PSQ;
                end
            end
            S_CHK:
            begin
                if (x_reg == WIDTH'(1) || x_reg == nm1_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_WNEXT;
                end
                else
                begin
                    r_next     = CNT_W'(1);
                    state_next = S_SQL;
                end
            end
            S_SQL:
            begin
                if (r_reg >= s_reg)
                begin
                    res_next   = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    state_next   = S_SQW;
                end
            end
            S_SQW:
            begin
                if (mm_done)
                begin
                    x_next = mm_product;
                    if (mm_product == nm1_reg)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_WNEXT;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = S_SQL;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    prime_next     = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        nm1_reg   <= nm1_next;
        d_reg     <= d_next;
        dsh_reg   <= dsh_next;
        base_reg  <= base_next;
        x_reg     <= x_next;
        s_reg     <= s_next;
        e_reg     <= e_next;
        r_reg     <= r_next;
        k_reg     <= k_next;
        res_reg   <= res_next;
        prime_reg <= prime_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign is_probable_prime = prime_reg;

endmodule

### rtl/core/mrpt_checker.sv
// ----------------------------------------------------------------------------
// mrpt_checker
// port-level checks of the prime tester, bound to the top level
// ----------------------------------------------------------------------------
`include "miller_rabin_prime_test_macros.svh"

module mrpt_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [mrpt_pkg::WIDTH-1:0]       candidate,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             is_probable_prime,
    input logic                             cfg_we
);
    import mrpt_pkg::*;

    logic in_xfer;
    logic small_cand;

    assign in_xfer    = in_valid && in_ready;
    assign small_cand = (candidate < WIDTH'(2));

    // stalled result holds
    `MRPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(is_probable_prime), "result changed while stalled")

    // one transaction in work at a time
    `MRPT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_xfer, !in_ready, "input accepted twice in a row")

    // with the output empty, a candidate below two goes through the finish state and comes back composite
    `MRPT_ASSERT_NEXT(a_small_fast, clk, rst_n, in_xfer && small_cand && !out_valid, ##1 (out_valid && !is_probable_prime), "small candidate not rejected")

    // a new result appears as the block goes idle
    `MRPT_ASSERT_NOW(a_result_idle, clk, rst_n, $rose(out_valid), in_ready && $past(!in_ready), "result without finishing work")

    // configuration only while idle
    `MRPT_ASSERT_NOW(a_cfg_idle, clk, rst_n, cfg_we, in_ready, "configuration written while busy")

endmodule

bind miller_rabin_prime_test mrpt_checker u_mrpt_checker (.*);

### test/miller_rabin_prime_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_tb
// self-checking bench for the probable-prime tester
// ----------------------------------------------------------------------------
// candidates go in over a valid/ready channel with random gaps and come back
// as one verdict each; every verdict is checked against a local copy of the
// witness registers and a strong-probable-prime computation done at double
// width. directed cases cover tiny candidates, strong pseudoprimes, witnesses
// that are multiples of the candidate, zero and clipped witness counts and
// unused register indexes; then random candidates run under several witness
// settings, with a long output stall and a final run without idle cycles.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_tb;

    import mrpt_pkg::*;

    localparam int W           = WIDTH;
    localparam int HOLD_CYCLES = 5000;
    localparam int SETTLE      = 14000;

    localparam logic [COUNT_W-1:0] DEFAULT_COUNT = 3'd3;

    bit                     clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [W-1:0]           candidate;
    logic                   out_valid;
    logic                   out_ready;
    logic                   is_probable_prime;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [COUNT_W-1:0]     wit_count = DEFAULT_COUNT;
    logic [W-1:0]           wit_base [MAX_WITNESSES] = '{32'd2, 32'd7, 32'd61, 32'd0};

    bit                     verdict_q [$];
    bit                     want;
    int                     mismatches = 0;
    bit                     quiet = 1'b0;
    int                     hold_req = 0;
    int                     hold_done = 0;

    logic [31:0] prime_tab [0:17] = '{
        32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd31, 32'd61, 32'd127,
        32'd257, 32'd8191, 32'd65521, 32'd65537, 32'd131071, 32'd1000000007,
        32'd998244353, 32'd2147483647, 32'd4294967291
    };

    logic [31:0] pseudo_tab [0:10] = '{
        32'd561, 32'd1105, 32'd1729, 32'd2047, 32'd3277, 32'd4033, 32'd4681,
        32'd8321, 32'd1373653, 32'd25326001, 32'd3215031751
    };

    miller_rabin_prime_test uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .candidate         (candidate),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .is_probable_prime (is_probable_prime),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

    // x * y mod m with the product held at double width
    function automatic logic [W-1:0] modmul(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] m);
        logic [2*W-1:0] prod;
        logic [2*W-1:0] rem;
        prod = x;
        prod = prod * y;
        rem  = prod % m;
        return rem[W-1:0];
    endfunction

    function automatic logic [W-1:0] modexp(input logic [W-1:0] b, input logic [W-1:0] e,
                                            input logic [W-1:0] m);
        logic [W-1:0] acc;
        logic [W-1:0] sq;
        logic [W-1:0] rest;
        acc  = 1;
        sq   = b;
        rest = e;
        while (rest != 0)
        begin
            if (rest[0])
                acc = modmul(acc, sq, m);
            sq   = modmul(sq, sq, m);
            rest = rest >> 1;
        end
        return acc;
    endfunction

    function automatic bit expected_verdict(input logic [W-1:0] n);
        logic [W-1:0] nm1;
        logic [W-1:0] d;
        logic [W-1:0] a;
        logic [W-1:0] x;
        int           s;
        int           used;
        int           k;
        int           r;
        bit           passed;
        if (n < 2)
            return 1'b0;
        nm1 = n - 1;
        d   = nm1;
        s   = 0;
        while (!d[0])
        begin
            d = d >> 1;
            s++;
        end
        used = (int'(wit_count) > MAX_WITNESSES) ? MAX_WITNESSES : int'(wit_count);
        for (k = 0; k < used; k++)
        begin
            a = wit_base[k] % n;
            // a base that is a multiple of n says nothing, skip it
            if (a != 0)
            begin
                x      = modexp(a, d, n);
                passed = (x == 1) || (x == nm1);
                for (r = 1; r < s && !passed; r++)
                begin
                    x      = modmul(x, x, n);
                    passed = (x == nm1);
                end
                if (!passed)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [W-1:0] pick_candidate();
        logic [2*W-1:0] prod;
        case ($urandom_range(0, 9))
            0, 1:
                return prime_tab[$urandom_range(0, 17)];
            2, 3:
            begin
                prod = prime_tab[$urandom_range(0, 17)];
                prod = prod * prime_tab[$urandom_range(0, 17)];
                return prod[W-1:0];
            end
            4:
                return pseudo_tab[$urandom_range(0, 10)];
            5, 6:
                return $urandom_range(0, 300);
            7:
                return $urandom_range(0, 65535);
            default:
                return $urandom;
        endcase
    endfunction

    function automatic logic [W-1:0] pick_witness();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(2, 100);
            default: return $urandom;
        endcase
    endfunction

    // one input transaction; valid stays high afterwards unless a gap follows
    task automatic send_candidate(input logic [W-1:0] value);
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdict_q.push_back(expected_verdict(value));
        @(negedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        if (idx == REG_WITNESS_COUNT)
            wit_count = value[COUNT_W-1:0];
        else if (idx >= REG_WITNESS_0 && idx <= REG_WITNESS_LAST
                 && int'(idx - REG_WITNESS_0) < MAX_WITNESSES)
            wit_base[WIT_IDX_W'(idx - REG_WITNESS_0)] = value;
    endtask

    task automatic set_witnesses(input logic [COUNT_W-1:0] count, input logic [W-1:0] b0,
                                 input logic [W-1:0] b1, input logic [W-1:0] b2,
                                 input logic [W-1:0] b3);
        write_reg(REG_WITNESS_COUNT, CFG_DATA_W'(count));
        write_reg(REG_WITNESS_0, b0);
        write_reg(REG_WITNESS_0 + 3'd1, b1);
        write_reg(REG_WITNESS_0 + 3'd2, b2);
        write_reg(REG_WITNESS_0 + 3'd3, b3);
    endtask

    task automatic test_reset_defaults();
        send_candidate(32'd0);
        send_candidate(32'd1);
        send_candidate(32'd2);
        send_candidate(32'd3);
        send_candidate(32'd4);
        send_candidate(32'd561);
        send_candidate(32'd2047);
        send_candidate(32'd1373653);
        send_candidate(32'd3215031751);
        send_candidate(32'd2147483647);
        send_candidate(32'd4294967291);
        send_candidate(32'hFFFF_FFFF);
        wait_results();
    endtask

    task automatic test_single_witness();
        write_reg(REG_WITNESS_COUNT, 32'd1);
        write_reg(REG_WITNESS_0, 32'd2);
        send_candidate(32'd2047);
        send_candidate(32'd4681);
        send_candidate(32'd1);
        send_candidate(32'd4294967291);
        wait_results();
        // base divisible by the candidate gets skipped
        write_reg(REG_WITNESS_0, 32'hFFFF_FFFF);
        send_candidate(32'hFFFF_FFFF);
        send_candidate(32'd65535);
        wait_results();
    endtask

    task automatic test_no_witnesses();
        write_reg(REG_WITNESS_COUNT, 32'd0);
        send_candidate(32'd9);
        send_candidate(32'd1);
        send_candidate(32'd2);
        wait_results();
    endtask

    task automatic test_clipped_count();
        int u;
        set_witnesses(3'd7, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd5);
        // unused indexes must not touch anything
        for (u = int'(REG_WITNESS_LAST) + 1; u < 2 ** CFG_IDX_W; u++)
            write_reg(CFG_IDX_W'(u), 32'd0);
        send_candidate(32'd561);
        send_candidate(32'd4294967291);
        send_candidate(32'd3215031751);
        wait_results();
    endtask

    task automatic test_random_candidates();
        int phase;
        int i;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       set_witnesses(DEFAULT_COUNT, 32'd2, 32'd7, 32'd61, 32'd0);
                1:       set_witnesses(3'd4, 32'd2, 32'd3, 32'd5, 32'd7);
                default: set_witnesses(COUNT_W'($urandom_range(0, 7)), pick_witness(),
                                       pick_witness(), pick_witness(), pick_witness());
            endcase
            for (i = 0; i < 12; i++)
                send_candidate(pick_candidate());
            wait_results();
        end
    endtask

    task automatic test_output_stall();
        int i;
        set_witnesses(DEFAULT_COUNT, 32'd2, 32'd7, 32'd61, 32'd0);
        hold_req = hold_req + 1;
        for (i = 0; i < 6; i++)
            send_candidate($urandom_range(2, 255));
        wait_results();
    endtask

    task automatic test_steady_stream();
        int i;
        quiet = 1'b1;
        for (i = 0; i < 14; i++)
            send_candidate(pick_candidate());
        wait_results();
    endtask

    // output side: random ready bursts, plus a long hold on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_done != hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = hold_done + 1;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 24)) @(negedge clk);
            end
        end
    end

    // result transaction check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result with nothing pending, expected none, actual %0b",
                         $time, is_probable_prime);
                mismatches++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (is_probable_prime !== want)
                begin
                    $display("%0t: is_probable_prime mismatch, expected %0b, actual %0b",
                             $time, want, is_probable_prime);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        candidate = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_single_witness();
        test_no_witnesses();
        test_clipped_count();
        test_random_candidates();
        test_output_stall();
        test_steady_stream();

        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
